// File: src/chunk_slot_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Chunk slot allocator assertion macros
// Clocked assertion shorthands shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef CHUNK_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define CHUNK_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/csa_pkg.sv
// ----------------------------------------------------------------------------
// Chunk slot allocator package
// Sizes, register indexes, opcodes and sequencer states of the allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int MAX_RADIUS = 24;
  localparam int COORD_BITS = 24;

  localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;
  localparam int DEPTH      = SIDE_MAX * SIDE_MAX;
  localparam int SLOT_W     = $clog2(DEPTH + 1);
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
  localparam int RAD_W      = 5;
  localparam int OFS_W      = COORD_BITS + 2;
  localparam int OWNER_W    = 1 + 2 * COORD_BITS;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_W      = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * SLOT_W + 4;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int RAD_MIN    = 2;
  localparam int RAD_RESET  = 8;
  localparam int SIDE_RESET = 2 * RAD_RESET + 1;
  localparam int CAP_RESET  = SIDE_RESET * SIDE_RESET;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RENDER_DIST = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OP,
    ST_POP,
    ST_FINISH
  } st_t;

endpackage

// File: src/chunk_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Chunk slot allocator
// Hands out and releases storage slots for chunk positions and reports the
// window grid entry each success touches.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake; in_tuser is the opcode (alloc or free),
//           in_tdata carries chunk_x and chunk_z.
//   out_* : one result per request, held in an output register until taken.
//   cfg_* : register writes (center x, center z, render distance) while idle;
//           a render distance write re-arms the slot store at once.
// Timing: a request scans n owner table entries, where n is the number of
//   distinct slots handed out since the last store init (at most 2401), and
//   a popped reused slot adds the ST_POP step. The owner table is scanned one
//   entry per cycle through its single RAM read port; that scan dominates.
// in_tready is high only while the sequencer is idle; a new request may be
//   taken while the previous result still waits. A stalled receiver holds
//   the sequencer in its final step until the output register frees.
// Reset: center at (-1,-1), radius 8, 289 free slots, slot 0 handed out first.
//   No clearing pass is needed; a watermark marks never-used table entries.
// ----------------------------------------------------------------------------
module chunk_slot_allocator_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [csa_pkg::IN_DATA_W-1:0]          in_tdata,  // chunk_x, chunk_z
  input  logic                                   in_tuser,  // opcode
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // slot, slot_ok, already_held, grid_write, grid_index, grid_slot_valid, pad
  output logic [csa_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  logic                                   cfg_we,
  input  logic [csa_pkg::REG_IDX_W-1:0]          cfg_addr,
  input  logic [csa_pkg::CFG_W-1:0]              cfg_wdata
);

  localparam int CB   = csa_pkg::COORD_BITS;
  localparam int SW   = csa_pkg::SLOT_W;
  localparam int AW   = csa_pkg::ADDR_W;
  localparam int SDW  = csa_pkg::SIDE_W;
  localparam int RW   = csa_pkg::RAD_W;
  localparam int OW   = csa_pkg::OFS_W;

  csa_pkg::st_t state_r, state_nxt;

  logic signed [CB-1:0] cx_r, cx_nxt, cz_r, cz_nxt;
  logic [RW-1:0]        rad_r, rad_nxt;
  logic [SDW-1:0]       side_r, side_nxt;
  logic [SW-1:0]        cap_r, cap_nxt, fc_r, fc_nxt, wm_r, wm_nxt;

  logic                 op_r, op_nxt;
  logic [CB-1:0]        x_r, x_nxt, z_r, z_nxt;
  logic signed [OW-1:0] lx_r, lx_nxt, lz_r, lz_nxt;
  logic [SW-1:0]        idx_r, idx_nxt, ridx_r, ridx_nxt, found_r, found_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic                 pend_r, pend_nxt, hit_r, hit_nxt, ok_r, ok_nxt;
  logic                 held_r, held_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [csa_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                          own_we;
  logic [AW-1:0]                 own_waddr;
  logic [csa_pkg::OWNER_W-1:0]   own_wdata, own_rdata;
  logic                          stk_we;
  logic [SW-1:0]                 stk_rdata;

  logic [SW-1:0]        used_cnt, fc_m1;
  logic                 scan_hit, out_room;
  logic [CB-1:0]        in_x, in_z;
  logic signed [OW-1:0] cx_ext, cz_ext, rad_ext, side_ext;
  logic                 lx_in, lz_in, gw, gvalid;
  logic [2*SDW-1:0]     row_prod, side_sq;
  logic [SW-1:0]        gidx;
  logic [RW-1:0]        rad_cfg;
  logic [SDW-1:0]       side_cfg;

  assign used_cnt = cap_r - wm_r;
  assign fc_m1    = fc_r - SW'(1);
  assign in_x     = in_tdata[CB-1:0];
  assign in_z     = in_tdata[2*CB-1:CB];
  assign cx_ext   = OW'(cx_r);
  assign cz_ext   = OW'(cz_r);
  assign rad_ext  = $signed({{(OW-RW){1'b0}}, rad_r});
  assign side_ext = $signed({{(OW-SDW){1'b0}}, side_r});
  assign scan_hit = pend_r && own_rdata[csa_pkg::OWNER_W-1]
                    && (own_rdata[2*CB-1:CB] == x_r) && (own_rdata[CB-1:0] == z_r);
  assign out_room = !out_valid_r || out_tready;

  assign lx_in    = !lx_r[OW-1] && (lx_r < side_ext);
  assign lz_in    = !lz_r[OW-1] && (lz_r < side_ext);
  assign gw       = ok_r && lx_in && lz_in;
  assign row_prod = lz_r[SDW-1:0] * side_r;
  assign gidx     = gw ? (SW'(row_prod) + SW'(lx_r[SDW-1:0])) : '0;
  assign gvalid   = gw && (op_r == csa_pkg::OP_ALLOC);

  always_comb begin
    rad_cfg = cfg_wdata[RW-1:0];
    if (rad_cfg < RW'(csa_pkg::RAD_MIN)) begin
      rad_cfg = RW'(csa_pkg::RAD_MIN);
    end else if (rad_cfg > RW'(csa_pkg::MAX_RADIUS)) begin
      rad_cfg = RW'(csa_pkg::MAX_RADIUS);
    end
    side_cfg = SDW'({rad_cfg, 1'b1});
    side_sq  = side_cfg * side_cfg;
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cz_nxt        = cz_r;
    rad_nxt       = rad_r;
    side_nxt      = side_r;
    cap_nxt       = cap_r;
    fc_nxt        = fc_r;
    wm_nxt        = wm_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    z_nxt         = z_r;
    lx_nxt        = lx_r;
    lz_nxt        = lz_r;
    idx_nxt       = idx_r;
    ridx_nxt      = ridx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    pend_nxt      = 1'b0;
    hit_nxt       = hit_r;
    ok_nxt        = ok_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    own_we        = 1'b0;
    own_waddr     = slot_r[AW-1:0];
    own_wdata     = {1'b1, x_r, z_r};
    stk_we        = 1'b0;
    in_tready     = (state_r == csa_pkg::ST_IDLE);

    unique case (state_r)
      csa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          x_nxt     = in_x;
          z_nxt     = in_z;
          lx_nxt    = OW'($signed(in_x)) - cx_ext + rad_ext;
          lz_nxt    = OW'($signed(in_z)) - cz_ext + rad_ext;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          ok_nxt    = 1'b0;
          held_nxt  = 1'b0;
          slot_nxt  = '0;
          state_nxt = csa_pkg::ST_SCAN;
        end
      end
      csa_pkg::ST_SCAN: begin
        if (scan_hit) begin
          found_nxt = ridx_r;
          hit_nxt   = 1'b1;
          state_nxt = csa_pkg::ST_OP;
        end else if (idx_r < used_cnt) begin
          pend_nxt  = 1'b1;
          ridx_nxt  = idx_r;
          idx_nxt   = idx_r + SW'(1);
        end else if (!pend_r) begin
          state_nxt = csa_pkg::ST_OP;
        end else begin
          state_nxt = csa_pkg::ST_OP;
        end
      end
      csa_pkg::ST_OP: begin
        state_nxt = csa_pkg::ST_FINISH;
        priority if (op_r == csa_pkg::OP_ALLOC && hit_r) begin
          slot_nxt = found_r;
          ok_nxt   = 1'b1;
          held_nxt = 1'b1;
        end else if (op_r == csa_pkg::OP_ALLOC && fc_r != '0) begin
          if (fc_r == wm_r) begin
            slot_nxt  = cap_r - fc_r;
            ok_nxt    = 1'b1;
            fc_nxt    = fc_m1;
            wm_nxt    = fc_m1;
            own_we    = 1'b1;
            own_waddr = AW'(cap_r - fc_r);
          end else begin
            state_nxt = csa_pkg::ST_POP;
          end
        end else if (op_r == csa_pkg::OP_FREE && hit_r) begin
          slot_nxt  = found_r;
          ok_nxt    = 1'b1;
          own_we    = 1'b1;
          own_waddr = found_r[AW-1:0];
          own_wdata = {1'b0, x_r, z_r};
          stk_we    = 1'b1;
          fc_nxt    = fc_r + SW'(1);
        end else begin
          ok_nxt = 1'b0;
        end
      end
      csa_pkg::ST_POP: begin
        slot_nxt  = stk_rdata;
        ok_nxt    = 1'b1;
        fc_nxt    = fc_m1;
        own_we    = 1'b1;
        own_waddr = stk_rdata[AW-1:0];
        state_nxt = csa_pkg::ST_FINISH;
      end
      csa_pkg::ST_FINISH: begin
        if (out_room) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = csa_pkg::OUT_DATA_W'({gvalid, gidx, gw, held_r, ok_r, slot_r});
          state_nxt     = csa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csa_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_addr)
        csa_pkg::REG_CENTER_X: begin
          cx_nxt = cfg_wdata[CB-1:0];
        end
        csa_pkg::REG_CENTER_Z: begin
          cz_nxt = cfg_wdata[CB-1:0];
        end
        csa_pkg::REG_RENDER_DIST: begin
          rad_nxt  = rad_cfg;
          side_nxt = side_cfg;
          cap_nxt  = SW'(side_sq);
          fc_nxt   = SW'(side_sq);
          wm_nxt   = SW'(side_sq);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csa_pkg::ST_IDLE;
      cx_r        <= '1;
      cz_r        <= '1;
      rad_r       <= RW'(csa_pkg::RAD_RESET);
      side_r      <= SDW'(csa_pkg::SIDE_RESET);
      cap_r       <= SW'(csa_pkg::CAP_RESET);
      fc_r        <= SW'(csa_pkg::CAP_RESET);
      wm_r        <= SW'(csa_pkg::CAP_RESET);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cz_r        <= cz_nxt;
      rad_r       <= rad_nxt;
      side_r      <= side_nxt;
      cap_r       <= cap_nxt;
      fc_r        <= fc_nxt;
      wm_r        <= wm_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    z_r         <= z_nxt;
    lx_r        <= lx_nxt;
    lz_r        <= lz_nxt;
    idx_r       <= idx_nxt;
    ridx_r      <= ridx_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    hit_r       <= hit_nxt;
    ok_r        <= ok_nxt;
    held_r      <= held_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  csa_ram #(
    .WIDTH (csa_pkg::OWNER_W),
    .DEPTH (csa_pkg::DEPTH)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (own_rdata)
  );

  csa_ram #(
    .WIDTH (SW),
    .DEPTH (csa_pkg::DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (fc_r[AW-1:0]),
    .wdata (found_r),
    .raddr (fc_m1[AW-1:0]),
    .rdata (stk_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`include "chunk_slot_allocator_unit_assert.svh"

  `CSA_ASSERT(a_count_order, 1'b1, (wm_r <= fc_r) && (fc_r <= cap_r),
              "free count outside watermark and capacity")
  `CSA_ASSERT(a_hit_in_range, (state_r == csa_pkg::ST_SCAN) && scan_hit,
              ridx_r < used_cnt, "owner hit beyond used entries")
  `CSA_ASSERT(a_slot_in_cap, out_valid_r && out_tdata_r[SW],
              out_tdata_r[SW-1:0] < cap_r, "granted slot beyond capacity")
  `CSA_ASSERT(a_grid_flags, out_valid_r && out_tdata_r[2*SW+3],
              out_tdata_r[SW+2] && out_tdata_r[SW], "grid entry valid without write")
  `CSA_ASSERT_NEXT(a_pop_count, (state_r == csa_pkg::ST_POP) && !cfg_we,
                   fc_r == $past(fc_r) - SW'(1), "pop did not drop free count")

endmodule

// File: src/csa_ram.sv
// ----------------------------------------------------------------------------
// Chunk slot allocator RAM
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Chunk slot allocator testbench
// Sends allocate and free requests through the request stream, including the
// window corners, coordinate extremes, a full slot store and traffic under
// several window settings. Every result is checked field by field against a
// slot store and window model kept here. The sender works in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] C_MIN = 24'sh800000;

  typedef struct packed {
    logic        gvalid;
    logic [11:0] gidx;
    logic        gw;
    logic        held;
    logic        ok;
    logic [11:0] slot;
  } slot_result_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [csa_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // chunk_x, chunk_z
  logic                           in_tuser = 1'b0; // opcode
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // slot, slot_ok, already_held, grid_write, grid_index, grid_slot_valid, pad
  logic [csa_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we = 1'b0;
  logic [csa_pkg::REG_IDX_W-1:0]  cfg_addr = '0;
  logic [csa_pkg::CFG_W-1:0]      cfg_wdata = '0;

  chunk_slot_allocator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // slot store and window model
  logic                   held_valid [csa_pkg::DEPTH];
  logic signed [23:0]     held_x     [csa_pkg::DEPTH];
  logic signed [23:0]     held_z     [csa_pkg::DEPTH];
  int                     vacant_stack [csa_pkg::DEPTH];
  int                     vacant_count;
  int                     slot_capacity;
  logic signed [23:0]     win_cx;
  logic signed [23:0]     win_cz;
  int                     win_radius;

  slot_result_t pending_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           tx_burst = 0;
  int           rx_run = 0;
  int           rx_pick;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void rearm_slot_store();
    int side;
    side = 2 * win_radius + 1;
    slot_capacity = side * side;
    for (int i = 0; i < csa_pkg::DEPTH; i++) begin
      held_valid[i] = 1'b0;
      held_x[i] = '0;
      held_z[i] = '0;
      vacant_stack[i] = (i < slot_capacity) ? slot_capacity - 1 - i : 0;
    end
    vacant_count = slot_capacity;
  endfunction

  function automatic slot_result_t predict_slot_result(logic op, logic signed [23:0] x,
                                                       logic signed [23:0] z);
    slot_result_t r;
    int found;
    bit hit;
    longint lx, lz;
    int side;
    r = '0;
    found = 0;
    hit = 0;
    side = 2 * win_radius + 1;
    for (int i = 0; i < slot_capacity; i++) begin
      if (held_valid[i] && held_x[i] == x && held_z[i] == z) begin
        found = i;
        hit = 1;
        break;
      end
    end
    if (op == csa_pkg::OP_ALLOC) begin
      if (hit) begin
        r.slot = 12'(found);
        r.ok = 1'b1;
        r.held = 1'b1;
      end else if (vacant_count > 0) begin
        vacant_count--;
        found = vacant_stack[vacant_count];
        held_valid[found] = 1'b1;
        held_x[found] = x;
        held_z[found] = z;
        r.slot = 12'(found);
        r.ok = 1'b1;
      end
      r.gvalid = r.ok;
    end else if (hit) begin
      r.slot = 12'(found);
      r.ok = 1'b1;
      held_valid[found] = 1'b0;
      vacant_stack[vacant_count] = found;
      vacant_count++;
    end
    if (r.ok) begin
      lx = longint'(x) - (longint'(win_cx) - longint'(win_radius));
      lz = longint'(z) - (longint'(win_cz) - longint'(win_radius));
      if (lx >= 0 && lz >= 0 && lx < side && lz < side) begin
        r.gw = 1'b1;
        r.gidx = 12'(lz * side + lx);
      end
    end
    if (!r.gw) r.gvalid = 1'b0;
    return r;
  endfunction

  task automatic write_reg(logic [csa_pkg::REG_IDX_W-1:0] idx,
                           logic [csa_pkg::CFG_W-1:0] value);
    int rad;
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    unique case (idx)
      csa_pkg::REG_CENTER_X: win_cx = value[23:0];
      csa_pkg::REG_CENTER_Z: win_cz = value[23:0];
      csa_pkg::REG_RENDER_DIST: begin
        rad = int'(value[4:0]);
        if (rad < csa_pkg::RAD_MIN) rad = csa_pkg::RAD_MIN;
        if (rad > csa_pkg::MAX_RADIUS) rad = csa_pkg::MAX_RADIUS;
        win_radius = rad;
        rearm_slot_store();
      end
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // radius write with random upper data bits
  task automatic write_radius(int value);
    logic [csa_pkg::CFG_W-1:0] w;
    w = csa_pkg::CFG_W'($urandom());
    w[4:0] = 5'(value);
    write_reg(csa_pkg::REG_RENDER_DIST, w);
  endtask

  task automatic send_request(logic op, logic signed [23:0] x, logic signed [23:0] z);
    slot_result_t want;
    if (tx_burst == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      tx_burst = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {z, x};
    do @(posedge clk); while (!in_tready);
    want = predict_slot_result(op, x, z);
    pending_results.insert(pending_results.size(), want);
    tx_burst--;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    tx_burst = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [23:0] near_coord(logic signed [23:0] c, int r);
    int d;
    d = $urandom_range(0, 2 * r + 2) - (r + 1);
    return 24'(int'(c) + d);
  endfunction

  task automatic test_reset_window();
    send_request(csa_pkg::OP_ALLOC, -24'sd1, -24'sd1);
    send_request(csa_pkg::OP_ALLOC, -24'sd1, -24'sd1);
    send_request(csa_pkg::OP_ALLOC, -24'sd9, -24'sd9);
    send_request(csa_pkg::OP_ALLOC, 24'sd7, 24'sd7);
    send_request(csa_pkg::OP_ALLOC, 24'sd8, -24'sd1);
    send_request(csa_pkg::OP_FREE, -24'sd1, -24'sd1);
    send_request(csa_pkg::OP_FREE, -24'sd1, -24'sd1);
    send_request(csa_pkg::OP_ALLOC, 24'sd100, 24'sd100);
    send_request(csa_pkg::OP_ALLOC, C_MIN, C_MAX);
    send_request(csa_pkg::OP_ALLOC, C_MAX, C_MIN);
    send_request(csa_pkg::OP_FREE, C_MAX, C_MIN);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(csa_pkg::REG_CENTER_X, C_MAX);
    write_reg(csa_pkg::REG_CENTER_Z, C_MIN);
    write_radius(0);
    send_request(csa_pkg::OP_ALLOC, C_MAX, C_MIN);
    send_request(csa_pkg::OP_ALLOC, C_MAX - 24'sd2, C_MIN + 24'sd2);
    send_request(csa_pkg::OP_ALLOC, C_MIN, C_MIN);
    send_request(csa_pkg::OP_FREE, C_MAX - 24'sd2, C_MIN + 24'sd2);
    wait_idle();
    write_reg(csa_pkg::REG_CENTER_X, C_MIN);
    write_reg(csa_pkg::REG_CENTER_Z, C_MAX);
    write_radius(31);
    send_request(csa_pkg::OP_ALLOC, C_MIN, C_MAX);
    send_request(csa_pkg::OP_ALLOC, C_MIN + 24'sd24, C_MAX - 24'sd24);
    send_request(csa_pkg::OP_ALLOC, C_MAX, C_MAX);
    wait_idle();
  endtask

  task automatic test_fill_and_drain();
    int start;
    int k;
    write_reg(csa_pkg::REG_CENTER_X, csa_pkg::CFG_W'($urandom()));
    write_reg(csa_pkg::REG_CENTER_Z, csa_pkg::CFG_W'($urandom()));
    write_radius(csa_pkg::RAD_MIN);
    start = $urandom_range(0, 48);
    for (int i = 0; i < 30; i++) begin
      k = (start + i) % 49;
      send_request(csa_pkg::OP_ALLOC, 24'(int'(win_cx) + k % 7 - 3),
                   24'(int'(win_cz) + k / 7 - 3));
    end
    for (int i = 0; i < 10; i++)
      send_request(csa_pkg::OP_ALLOC, near_coord(win_cx, 2), near_coord(win_cz, 2));
    for (int i = 0; i < 15; i++)
      send_request(csa_pkg::OP_FREE, near_coord(win_cx, 2), near_coord(win_cz, 2));
    for (int i = 0; i < 10; i++)
      send_request(csa_pkg::OP_ALLOC, near_coord(win_cx, 2), near_coord(win_cz, 2));
    wait_idle();
  endtask

  task automatic run_traffic(int count);
    int kind;
    int start;
    int pick;
    logic op;
    logic signed [23:0] x, z;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      op = (kind >= 55 && kind < 80) ? csa_pkg::OP_FREE : csa_pkg::OP_ALLOC;
      x = near_coord(win_cx, win_radius);
      z = near_coord(win_cz, win_radius);
      if (kind >= 80 && kind < 90) begin
        start = $urandom_range(0, slot_capacity - 1);
        pick = -1;
        for (int j = 0; j < slot_capacity && pick < 0; j++)
          if (held_valid[(start + j) % slot_capacity]) pick = (start + j) % slot_capacity;
        if (pick >= 0) begin
          x = held_x[pick];
          z = held_z[pick];
        end
        op = logic'($urandom_range(0, 1));
      end else if (kind >= 90) begin
        x = 24'($urandom());
        z = 24'($urandom());
        op = logic'($urandom_range(0, 1));
      end
      send_request(op, x, z);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    write_reg(csa_pkg::REG_CENTER_X, '0);
    write_reg(csa_pkg::REG_CENTER_Z, '0);
    write_reg(csa_pkg::REG_RENDER_DIST, 24'hFFFFE2);
    run_traffic(44);
    write_reg(csa_pkg::REG_CENTER_X, csa_pkg::CFG_W'($urandom()));
    write_reg(csa_pkg::REG_CENTER_Z, csa_pkg::CFG_W'($urandom()));
    write_radius(3);
    run_traffic(44);
    write_reg(csa_pkg::REG_CENTER_X, C_MIN);
    write_reg(csa_pkg::REG_CENTER_Z, C_MAX);
    write_radius(csa_pkg::MAX_RADIUS);
    run_traffic(44);
    write_reg(csa_pkg::REG_CENTER_X, csa_pkg::CFG_W'($urandom()));
    write_reg(csa_pkg::REG_CENTER_Z, csa_pkg::CFG_W'($urandom()));
    write_radius($urandom_range(0, 7));
    run_traffic(44);
  endtask

  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_pick = $urandom_range(0, 7);
      if (rx_pick == 0) begin
        out_tready <= 1'b1;
        rx_run <= 60;
      end else if (rx_pick < 4) begin
        out_tready <= 1'b0;
        rx_run <= $urandom_range(1, 12);
      end else begin
        out_tready <= 1'b1;
        rx_run <= $urandom_range(1, 8);
      end
    end else begin
      rx_run <= rx_run - 1;
    end
  end

  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    got = out_tdata[27:0];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: slot %0d ok %0b held %0b gw %0b gidx %0d gv %0b",
                   got.slot, got.ok, got.held, got.gw, got.gidx, got.gvalid);
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot || got.ok !== want.ok || got.held !== want.held ||
            got.gw !== want.gw || got.gidx !== want.gidx || got.gvalid !== want.gvalid) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected slot %0d ok %0b held %0b gw %0b gidx %0d gv %0b",
                     want.slot, want.ok, want.held, want.gw, want.gidx, want.gvalid);
            $display("          got      slot %0d ok %0b held %0b gw %0b gidx %0d gv %0b",
                     got.slot, got.ok, got.held, got.gw, got.gidx, got.gvalid);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    win_cx = -24'sd1;
    win_cz = -24'sd1;
    win_radius = csa_pkg::RAD_RESET;
    rearm_slot_store();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_register_extremes();
    test_fill_and_drain();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
